[src/prk_pkg.sv]
`default_nettype none
package prk_pkg;

    localparam int FIELD_W   = 48;
    localparam int TIME_W    = 47;
    localparam int IN_DATA_W = 5 * FIELD_W;
    localparam int OUT_RAW_W = 8 * FIELD_W + TIME_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int IN_USER_W = 2;

    localparam int C_W    = 24;
    localparam int G_W    = 32;
    localparam int H_W    = 24;
    localparam int TRIG_W = 18;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam int REG_FRAC  = 24;
    localparam int TRIG_FRAC = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 3'd4;

    localparam logic [C_W-1:0]    RST_DRAG = 24'd41943;
    localparam logic [G_W-1:0]    RST_GRAV = 32'd536870912;
    localparam logic [H_W-1:0]    RST_STEP = 24'd167772;
    localparam logic [TRIG_W-1:0] RST_COS  = 18'd65536;
    localparam logic [TRIG_W-1:0] RST_SIN  = 18'd0;

    localparam int SLOT_W = 5;
    localparam int NSLOT  = 32;
    localparam int PC_W   = 7;

    localparam logic [SLOT_W-1:0] SL_PX  = 5'd0;
    localparam logic [SLOT_W-1:0] SL_PY  = 5'd1;
    localparam logic [SLOT_W-1:0] SL_PZ  = 5'd2;
    localparam logic [SLOT_W-1:0] SL_OX  = 5'd3;
    localparam logic [SLOT_W-1:0] SL_OY  = 5'd4;
    localparam logic [SLOT_W-1:0] SL_OZ  = 5'd5;
    localparam logic [SLOT_W-1:0] SL_VH  = 5'd6;
    localparam logic [SLOT_W-1:0] SL_VV  = 5'd7;
    localparam logic [SLOT_W-1:0] SL_EL  = 5'd8;
    localparam logic [SLOT_W-1:0] SL_GR  = 5'd9;
    localparam logic [SLOT_W-1:0] SL_HV  = 5'd10;
    localparam logic [SLOT_W-1:0] SL_U   = 5'd11;
    localparam logic [SLOT_W-1:0] SL_W   = 5'd12;
    localparam logic [SLOT_W-1:0] SL_T1  = 5'd13;
    localparam logic [SLOT_W-1:0] SL_T2  = 5'd14;
    localparam logic [SLOT_W-1:0] SL_SP  = 5'd15;
    localparam logic [SLOT_W-1:0] SL_SH  = 5'd16;
    localparam logic [SLOT_W-1:0] SL_SV  = 5'd17;
    localparam logic [SLOT_W-1:0] SL_DA  = 5'd18;
    localparam logic [SLOT_W-1:0] SL_DB  = 5'd19;
    localparam logic [SLOT_W-1:0] SL_DH  = 5'd20;
    localparam logic [SLOT_W-1:0] SL_DV  = 5'd21;
    localparam logic [SLOT_W-1:0] SL_RX  = 5'd22;
    localparam logic [SLOT_W-1:0] SL_RY  = 5'd23;
    localparam logic [SLOT_W-1:0] SL_RXO = 5'd24;
    localparam logic [SLOT_W-1:0] SL_RYO = 5'd25;

    localparam logic [PC_W-1:0] ADV_PC  = 7'd0;
    localparam logic [PC_W-1:0] OUT_PC  = 7'd102;
    localparam logic [PC_W-1:0] LOAD_PC = 7'd121;

    typedef enum logic [2:0] {
        OP_MUL, OP_SQRT, OP_DIV6, OP_ADD, OP_NEG, OP_HALF, OP_MOV
    } t_op;

    typedef enum logic [1:0] {
        SH_VAL, SH_REG, SH_TRIG
    } t_shf;

    typedef enum logic [3:0] {
        SRC_FILE, SRC_C, SRC_H, SRC_G, SRC_ONE, SRC_COS, SRC_SIN,
        SRC_LX, SRC_LY, SRC_LZ, SRC_LH, SRC_LV, SRC_ZERO
    } t_src;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_ISSUE, ST_RUN, ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
        t_shf shf;
    } t_alu_req;

    typedef struct packed {
        t_op               op;
        t_src              sa;
        logic [SLOT_W-1:0] ia;
        t_src              sb;
        logic [SLOT_W-1:0] ib;
        t_shf              shf;
        logic [SLOT_W-1:0] dst;
        logic              fin;
        logic              jmp;
    } t_uop;

    function automatic t_uop uf(t_op op, logic [SLOT_W-1:0] ia, logic [SLOT_W-1:0] ib,
                                t_shf shf, logic [SLOT_W-1:0] dst);
        t_uop u;
        u = '{op: op, sa: SRC_FILE, ia: ia, sb: SRC_FILE, ib: ib, shf: shf, dst: dst,
              fin: 1'b0, jmp: 1'b0};
        return u;
    endfunction

    function automatic t_uop uc(t_op op, logic [SLOT_W-1:0] ia, t_src sb,
                                t_shf shf, logic [SLOT_W-1:0] dst);
        t_uop u;
        u = '{op: op, sa: SRC_FILE, ia: ia, sb: sb, ib: SL_PX, shf: shf, dst: dst,
              fin: 1'b0, jmp: 1'b0};
        return u;
    endfunction

    function automatic t_uop us(t_op op, t_src sa, t_src sb, t_shf shf,
                                logic [SLOT_W-1:0] dst);
        t_uop u;
        u = '{op: op, sa: sa, ia: SL_PX, sb: sb, ib: SL_PX, shf: shf, dst: dst,
              fin: 1'b0, jmp: 1'b0};
        return u;
    endfunction

    // drag slopes of (u, w) into da, db
    function automatic t_uop slope_uop(logic [3:0] k);
        t_uop u;
        unique case (k)
            4'd0:  u = uf(OP_MUL, SL_U, SL_U, SH_VAL, SL_T1);
            4'd1:  u = uf(OP_MUL, SL_W, SL_W, SH_VAL, SL_T2);
            4'd2:  u = uf(OP_ADD, SL_T1, SL_T2, SH_VAL, SL_T1);
            4'd3:  u = uf(OP_SQRT, SL_T1, SL_T1, SH_VAL, SL_SP);
            4'd4:  u = uc(OP_MUL, SL_U, SRC_C, SH_REG, SL_T1);
            4'd5:  u = uf(OP_MUL, SL_T1, SL_SP, SH_VAL, SL_T1);
            4'd6:  u = uf(OP_NEG, SL_T1, SL_T1, SH_VAL, SL_DA);
            4'd7:  u = uc(OP_MUL, SL_W, SRC_C, SH_REG, SL_T1);
            4'd8:  u = uf(OP_MUL, SL_T1, SL_SP, SH_VAL, SL_T1);
            4'd9:  u = uf(OP_NEG, SL_T1, SL_T1, SH_VAL, SL_T1);
            4'd10: u = uf(OP_NEG, SL_GR, SL_GR, SH_VAL, SL_T2);
            4'd11: u = uf(OP_ADD, SL_T1, SL_T2, SH_VAL, SL_DB);
            default: u = uf(OP_MOV, SL_T1, SL_T1, SH_VAL, SL_T1);
        endcase
        return u;
    endfunction

    function automatic t_uop prk_rom(logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc) inside
            7'd0:  u = us(OP_MUL, SRC_G, SRC_ONE, SH_REG, SL_GR);
            7'd1:  u = us(OP_MUL, SRC_H, SRC_ONE, SH_REG, SL_HV);
            7'd2:  u = uf(OP_MOV, SL_VH, SL_VH, SH_VAL, SL_U);
            7'd3:  u = uf(OP_MOV, SL_VV, SL_VV, SH_VAL, SL_W);
            [7'd4:7'd15]:  u = slope_uop(4'(pc - 7'd4));
            7'd16: u = uf(OP_MOV, SL_DA, SL_DA, SH_VAL, SL_SH);
            7'd17: u = uf(OP_MOV, SL_DB, SL_DB, SH_VAL, SL_SV);
            7'd18, 7'd40: u = uc(OP_MUL, SL_DA, SRC_H, SH_REG, SL_T1);
            7'd19, 7'd22, 7'd41, 7'd44: u = uf(OP_HALF, SL_T1, SL_T1, SH_VAL, SL_T1);
            7'd20, 7'd42, 7'd63: u = uf(OP_ADD, SL_VH, SL_T1, SH_VAL, SL_U);
            7'd21, 7'd43: u = uc(OP_MUL, SL_DB, SRC_H, SH_REG, SL_T1);
            7'd23, 7'd45, 7'd65: u = uf(OP_ADD, SL_VV, SL_T1, SH_VAL, SL_W);
            [7'd24:7'd35]: u = slope_uop(4'(pc - 7'd24));
            7'd36, 7'd37, 7'd58, 7'd59, 7'd78:
                u = uf(OP_ADD, SL_SH, SL_DA, SH_VAL, SL_SH);
            7'd38, 7'd39, 7'd60, 7'd61, 7'd79:
                u = uf(OP_ADD, SL_SV, SL_DB, SH_VAL, SL_SV);
            [7'd46:7'd57]: u = slope_uop(4'(pc - 7'd46));
            7'd62: u = uc(OP_MUL, SL_DA, SRC_H, SH_REG, SL_T1);
            7'd64: u = uc(OP_MUL, SL_DB, SRC_H, SH_REG, SL_T1);
            [7'd66:7'd77]: u = slope_uop(4'(pc - 7'd66));
            7'd80: u = uf(OP_DIV6, SL_SH, SL_SH, SH_VAL, SL_DH);
            7'd81: u = uf(OP_DIV6, SL_SV, SL_SV, SH_VAL, SL_DV);
            7'd82: u = uf(OP_MOV, SL_PX, SL_PX, SH_VAL, SL_OX);
            7'd83: u = uf(OP_MOV, SL_PY, SL_PY, SH_VAL, SL_OY);
            7'd84: u = uf(OP_MOV, SL_PZ, SL_PZ, SH_VAL, SL_OZ);
            7'd85: u = uf(OP_HALF, SL_DH, SL_DH, SH_VAL, SL_T1);
            7'd86, 7'd87, 7'd92, 7'd93: u = uc(OP_MUL, SL_T1, SRC_H, SH_REG, SL_T1);
            7'd88: u = uc(OP_MUL, SL_VH, SRC_H, SH_REG, SL_T2);
            7'd89: u = uf(OP_ADD, SL_PY, SL_T2, SH_VAL, SL_PY);
            7'd90: u = uf(OP_ADD, SL_PY, SL_T1, SH_VAL, SL_PY);
            7'd91: u = uf(OP_HALF, SL_DV, SL_DV, SH_VAL, SL_T1);
            7'd94: u = uc(OP_MUL, SL_VV, SRC_H, SH_REG, SL_T2);
            7'd95: u = uf(OP_ADD, SL_PZ, SL_T2, SH_VAL, SL_PZ);
            7'd96: u = uf(OP_ADD, SL_PZ, SL_T1, SH_VAL, SL_PZ);
            7'd97: u = uc(OP_MUL, SL_DH, SRC_H, SH_REG, SL_T1);
            7'd98: u = uf(OP_ADD, SL_VH, SL_T1, SH_VAL, SL_VH);
            7'd99: u = uc(OP_MUL, SL_DV, SRC_H, SH_REG, SL_T1);
            7'd100: u = uf(OP_ADD, SL_VV, SL_T1, SH_VAL, SL_VV);
            7'd101: u = uf(OP_ADD, SL_EL, SL_HV, SH_VAL, SL_EL);
            7'd102: u = uc(OP_MUL, SL_PX, SRC_COS, SH_TRIG, SL_T1);
            7'd103: u = uc(OP_MUL, SL_PY, SRC_SIN, SH_TRIG, SL_T2);
            7'd104: u = uf(OP_ADD, SL_T1, SL_T2, SH_VAL, SL_RX);
            7'd105: u = uc(OP_MUL, SL_PX, SRC_SIN, SH_TRIG, SL_T1);
            7'd106, 7'd113: u = uf(OP_NEG, SL_T1, SL_T1, SH_VAL, SL_T1);
            7'd107: u = uc(OP_MUL, SL_PY, SRC_COS, SH_TRIG, SL_T2);
            7'd108: u = uf(OP_ADD, SL_T1, SL_T2, SH_VAL, SL_RY);
            7'd109: u = uc(OP_MUL, SL_OX, SRC_COS, SH_TRIG, SL_T1);
            7'd110: u = uc(OP_MUL, SL_OY, SRC_SIN, SH_TRIG, SL_T2);
            7'd111: u = uf(OP_ADD, SL_T1, SL_T2, SH_VAL, SL_RXO);
            7'd112: u = uc(OP_MUL, SL_OX, SRC_SIN, SH_TRIG, SL_T1);
            7'd114: u = uc(OP_MUL, SL_OY, SRC_COS, SH_TRIG, SL_T2);
            7'd115: u = uf(OP_ADD, SL_T1, SL_T2, SH_VAL, SL_RYO);
            7'd116: u = uf(OP_MOV, SL_PZ, SL_PZ, SH_VAL, SL_PZ);
            7'd117: u = uf(OP_MOV, SL_OZ, SL_OZ, SH_VAL, SL_OZ);
            7'd118: u = uf(OP_MOV, SL_EL, SL_EL, SH_VAL, SL_EL);
            7'd119: u = uf(OP_MOV, SL_VH, SL_VH, SH_VAL, SL_VH);
            7'd120: begin
                u = uf(OP_MOV, SL_VV, SL_VV, SH_VAL, SL_VV);
                u.fin = 1'b1;
            end
            7'd121: u = us(OP_MOV, SRC_LX, SRC_ZERO, SH_VAL, SL_PX);
            7'd122: u = us(OP_MOV, SRC_LY, SRC_ZERO, SH_VAL, SL_PY);
            7'd123: u = us(OP_MOV, SRC_LZ, SRC_ZERO, SH_VAL, SL_PZ);
            7'd124: u = us(OP_MOV, SRC_LH, SRC_ZERO, SH_VAL, SL_VH);
            7'd125: u = us(OP_MOV, SRC_LV, SRC_ZERO, SH_VAL, SL_VV);
            7'd126: begin
                u = us(OP_MOV, SRC_ZERO, SRC_ZERO, SH_VAL, SL_EL);
                u.jmp = 1'b1;
            end
            default: begin
                u = us(OP_MOV, SRC_ZERO, SRC_ZERO, SH_VAL, SL_T1);
                u.fin = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

[src/prk_alu.sv]
`default_nettype none
module prk_alu import prk_pkg::*; #(
    parameter int VW   = 48,
    parameter int FRAC = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_alu_req            i_req,
    input  wire logic signed [VW:0]  i_a,
    input  wire logic signed [VW:0]  i_b,
    output logic                     o_done,
    output logic signed [VW-1:0]     o_res
);

    localparam int OW = VW + 1;
    localparam int PW = 2 * VW;
    localparam int RW = (VW + FRAC) / 2;
    localparam int NW = 2 * RW;
    localparam int XW = (RW > VW) ? RW : VW;
    localparam int CW = $clog2(PW + 1);
    localparam logic [VW-1:0] VMAXU = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [OW:0] SMAX = (OW+1)'(VMAXU);
    localparam logic signed [OW:0] SMIN = ~SMAX;
    // divide by six as a multiply by a rounded-up reciprocal of 2^(VW+2)/6
    localparam int DIV_SH = VW + 2;
    localparam logic [VW+2:0] DIV_POW = (VW+3)'(1) << DIV_SH;
    localparam logic [VW+2:0] DIV_RCP_W =
        (DIV_POW + ((VW % 2 == 0) ? (VW+3)'(2) : (VW+3)'(4))) / (VW+3)'(6);
    localparam logic [VW-1:0] DIV_RCP = DIV_RCP_W[VW-1:0];

    logic            r_busy, r_fin, r_done;
    logic [CW-1:0]   r_cnt;
    t_op             r_op;
    t_shf            r_shf;
    logic            r_neg;
    logic [VW-1:0]   r_ma, r_mb;
    logic [PW-1:0]   r_acc;
    logic [NW-1:0]   r_n;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic signed [VW-1:0] r_res;

    logic            a_neg, b_neg;
    logic [OW-1:0]   a_mag_w, b_mag_w;
    logic [VW-1:0]   a_mag, b_mag;
    logic signed [OW:0]   s_sum;
    logic signed [OW-1:0] h_sum, h_res;
    logic signed [VW-1:0] simple_res;
    logic [PW-1:0]   acc_nx;
    logic [RW+1:0]   rem_sh, trial;
    logic [PW-1:0]   q, lim;
    logic [VW-1:0]   mag;
    logic [XW-1:0]   root_x;
    logic signed [VW-1:0] fin_res;
    logic [CW-1:0]   last;

    always_comb begin
        a_neg   = i_a[VW];
        b_neg   = i_b[VW];
        a_mag_w = a_neg ? OW'(-i_a) : OW'(i_a);
        b_mag_w = b_neg ? OW'(-i_b) : OW'(i_b);
        a_mag   = a_mag_w[VW-1:0];
        b_mag   = b_mag_w[VW-1:0];
        case (i_req.op)
            OP_ADD:  s_sum = (OW+1)'(i_a) + (OW+1)'(i_b);
            OP_NEG:  s_sum = -((OW+1)'(i_a));
            default: s_sum = (OW+1)'(i_a);
        endcase
        h_sum = i_a + OW'(a_neg);
        h_res = h_sum >>> 1;
        if (i_req.op == OP_HALF) begin
            simple_res = h_res[VW-1:0];
        end else if (s_sum > SMAX) begin
            simple_res = SMAX[VW-1:0];
        end else if (s_sum < SMIN) begin
            simple_res = SMIN[VW-1:0];
        end else begin
            simple_res = s_sum[VW-1:0];
        end
    end

    always_comb begin
        acc_nx = (r_acc << 1) + (r_mb[VW-1] ? PW'(r_ma) : '0);
        rem_sh = {r_rem[RW-1:0], r_n[NW-1:NW-2]};
        trial  = {r_root, 2'b01};
        last   = (r_op == OP_SQRT) ? CW'(RW - 1) : CW'(VW - 1);
    end

    always_comb begin
        case (r_shf)
            SH_REG:  q = r_acc >> REG_FRAC;
            SH_TRIG: q = r_acc >> TRIG_FRAC;
            default: q = r_acc >> FRAC;
        endcase
        if (r_op == OP_DIV6) begin
            q = r_acc >> DIV_SH;
        end
        lim    = PW'(VMAXU) + PW'(r_neg);
        mag    = (q > lim) ? lim[VW-1:0] : q[VW-1:0];
        root_x = XW'(r_root);
        case (r_op)
            OP_SQRT: fin_res = (root_x > XW'(VMAXU)) ? VMAXU : root_x[VW-1:0];
            default: fin_res = r_neg ? -mag : mag;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                if (i_req.op == OP_MUL || i_req.op == OP_SQRT || i_req.op == OP_DIV6) begin
                    r_busy <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end else if (r_busy && r_cnt == last) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_shf  <= i_req.shf;
            r_cnt  <= '0;
            r_res  <= simple_res;
            r_neg  <= (i_req.op == OP_MUL) ? (a_neg ^ b_neg) : a_neg;
            r_ma   <= a_mag;
            r_mb   <= (i_req.op == OP_DIV6) ? DIV_RCP : b_mag;
            r_acc  <= '0;
            r_n    <= NW'({i_a[VW-2:0], {FRAC{1'b0}}});
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            case (r_op)
                OP_SQRT: begin
                    r_n <= r_n << 2;
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                end
                default: begin
                    r_acc <= acc_nx;
                    r_mb  <= r_mb << 1;
                end
            endcase
        end else if (r_fin) begin
            r_res <= fin_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

[src/projectile_rk4_drag_step.sv]
`default_nettype none
// One beat in gives one beat out. An advance beat runs one fourth-order
// Runge-Kutta step with quadratic drag as a microcoded sequence of 121
// operations on one shared bit-serial unit: a multiply runs bit by bit, the
// divide by six runs as a multiply by a reciprocal, a square root runs bit by
// bit too, and an add, negate, halve or move finishes without the serial
// loop. s_tready is low while a beat is worked on; a finished result waits
// in the output register while the next beat is taken.
module projectile_rk4_drag_step import prk_pkg::*; #(
    parameter int VALUE_WIDTH = 48,
    parameter int FRAC_BITS   = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // load_x, load_y, load_z, load_vh, load_vv
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // command, on_ground
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // rot_x, rot_y, rot_z, rot_old_x, rot_old_y, rot_old_z, elapsed_out,
    // vel_h_out, vel_v_out, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int OW = VW + 1;
    localparam int LW = (VW > FIELD_W) ? VW : FIELD_W;
    localparam logic signed [LW-1:0] LMAX = signed'({{(LW-VW+1){1'b0}}, {(VW-1){1'b1}}});
    localparam logic signed [LW-1:0] LMIN = ~LMAX;

    logic [C_W-1:0]    r_drag;
    logic [G_W-1:0]    r_grav;
    logic [H_W-1:0]    r_step;
    logic [TRIG_W-1:0] r_cos, r_sin;

    t_state r_state, n_state;
    logic [PC_W-1:0] r_pc;
    t_uop uop;

    logic signed [VW-1:0] r_ld [0:4];
    logic signed [VW-1:0] n_ld [0:4];
    logic signed [LW-1:0] ld_ext;

    logic signed [OW-1:0] r_mem [0:NSLOT-1];
    logic [NSLOT-1:0]     r_vld;
    logic signed [OW-1:0] r_rd_a, r_rd_b;
    logic                 r_va, r_vb;
    logic signed [OW-1:0] file_a, file_b, op_a, op_b;

    t_alu_req alu_req;
    logic     alu_done;
    logic signed [VW-1:0] alu_res;

    logic signed [VW-1:0] r_rx, r_ry, r_rz, r_rxo, r_ryo, r_rzo, r_el, r_vh, r_vv;
    logic                 r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, out_pack;
    logic                 accept, out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_m_valid || m_tready;
    assign uop      = prk_rom(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag <= RST_DRAG;
            r_grav <= RST_GRAV;
            r_step <= RST_STEP;
            r_cos  <= RST_COS;
            r_sin  <= RST_SIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DRAG: r_drag <= i_cfg_data[C_W-1:0];
                CFG_GRAV: r_grav <= i_cfg_data[G_W-1:0];
                CFG_STEP: r_step <= i_cfg_data[H_W-1:0];
                CFG_COS:  r_cos  <= i_cfg_data[TRIG_W-1:0];
                CFG_SIN:  r_sin  <= i_cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // loads saturate into the value range
    always_comb begin
        ld_ext = '0;
        for (int i = 0; i < 5; i++) begin
            ld_ext = LW'(signed'(s_tdata[i*FIELD_W +: FIELD_W]));
            if (ld_ext > LMAX) begin
                n_ld[i] = LMAX[VW-1:0];
            end else if (ld_ext < LMIN) begin
                n_ld[i] = LMIN[VW-1:0];
            end else begin
                n_ld[i] = ld_ext[VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 5; i++) begin
                r_ld[i] <= n_ld[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_tvalid) n_state = ST_FETCH;
            ST_FETCH: n_state = ST_ISSUE;
            ST_ISSUE: n_state = ST_RUN;
            ST_RUN:   if (alu_done) n_state = uop.fin ? ST_EMIT : ST_FETCH;
            ST_EMIT:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (r_state == ST_IDLE);
        alu_req.start = (r_state == ST_ISSUE);
        alu_req.op    = uop.op;
        alu_req.shf   = uop.shf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= ADV_PC;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pc <= s_tuser[0] ? LOAD_PC : (s_tuser[1] ? OUT_PC : ADV_PC);
            end else if (r_state == ST_RUN && alu_done) begin
                r_pc <= uop.jmp ? OUT_PC : r_pc + 1'b1;
            end
        end
    end

    // scratch file, entries read as zero until written
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && alu_done) begin
            r_mem[uop.dst] <= OW'(alu_res);
        end
        r_rd_a <= r_mem[uop.ia];
        r_rd_b <= r_mem[uop.ib];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (r_state == ST_RUN && alu_done) begin
                r_vld[uop.dst] <= 1'b1;
            end
            r_va <= r_vld[uop.ia];
            r_vb <= r_vld[uop.ib];
        end
    end

    assign file_a = r_va ? r_rd_a : '0;
    assign file_b = r_vb ? r_rd_b : '0;

    function automatic logic signed [OW-1:0] pick(t_src s, logic signed [OW-1:0] f);
        logic signed [OW-1:0] v;
        case (s)
            SRC_FILE: v = f;
            SRC_C:    v = OW'(r_drag);
            SRC_H:    v = OW'(r_step);
            SRC_G:    v = OW'(r_grav);
            SRC_ONE:  v = OW'(1) << FRAC_BITS;
            SRC_COS:  v = OW'(signed'(r_cos));
            SRC_SIN:  v = OW'(signed'(r_sin));
            SRC_LX:   v = OW'(r_ld[0]);
            SRC_LY:   v = OW'(r_ld[1]);
            SRC_LZ:   v = OW'(r_ld[2]);
            SRC_LH:   v = OW'(r_ld[3]);
            SRC_LV:   v = OW'(r_ld[4]);
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        op_a = pick(uop.sa, file_a);
        op_b = pick(uop.sb, file_b);
    end

    prk_alu #(
        .VW   (VW),
        .FRAC (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // result fields pick up the writes that produce them
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && alu_done) begin
            case (uop.dst)
                SL_RX:  r_rx  <= alu_res;
                SL_RY:  r_ry  <= alu_res;
                SL_PZ:  r_rz  <= alu_res;
                SL_RXO: r_rxo <= alu_res;
                SL_RYO: r_ryo <= alu_res;
                SL_OZ:  r_rzo <= alu_res;
                SL_EL:  r_el  <= alu_res;
                SL_VH:  r_vh  <= alu_res;
                SL_VV:  r_vv  <= alu_res;
                default: ;
            endcase
        end
    end

    function automatic logic [FIELD_W-1:0] fld(logic signed [VW-1:0] v);
        logic signed [LW-1:0] e;
        e = LW'(v);
        return e[FIELD_W-1:0];
    endfunction

    always_comb begin
        out_pack = '0;
        out_pack[0*FIELD_W +: FIELD_W] = fld(r_rx);
        out_pack[1*FIELD_W +: FIELD_W] = fld(r_ry);
        out_pack[2*FIELD_W +: FIELD_W] = fld(r_rz);
        out_pack[3*FIELD_W +: FIELD_W] = fld(r_rxo);
        out_pack[4*FIELD_W +: FIELD_W] = fld(r_ryo);
        out_pack[5*FIELD_W +: FIELD_W] = fld(r_rzo);
        out_pack[6*FIELD_W +: TIME_W]  = TIME_W'(fld(r_el));
        out_pack[6*FIELD_W+TIME_W +: FIELD_W] = fld(r_vh);
        out_pack[7*FIELD_W+TIME_W +: FIELD_W] = fld(r_vv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_m_data <= out_pack;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule
`default_nettype wire

[dv/prk_checker.sv]
module prk_checker import prk_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    localparam longint VMAX = (64'sd1 <<< 47) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam longint ONE  = 64'sd1 <<< 24;

    logic [C_W-1:0] drag_c;
    logic [G_W-1:0] grav_c;
    logic [H_W-1:0] step_c;
    longint cos_c, sin_c;
    longint px, py, pz, ox, oy, oz, vh, vv, el;
    logic [OUT_DATA_W-1:0] result_q[$];
    int err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = result_q.size();

    function automatic longint clamp(longint v);
        return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        return clamp(a + b);
    endfunction

    function automatic longint sat_neg(longint a);
        return clamp(-a);
    endfunction

    function automatic longint mul_q(longint a, longint b, int sh);
        bit neg;
        bit [127:0] ma, mb, mag, lim;
        neg = (a < 0) != (b < 0);
        ma  = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
        mb  = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
        mag = (ma * mb) >> sh;
        lim = 128'(VMAX) + (neg ? 128'd1 : 128'd0);
        if (mag > lim)
            return neg ? VMIN : VMAX;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint speed_of(longint s);
        bit [127:0] n, sq;
        bit [63:0] r, c;
        n = {64'd0, 64'(s)} << 24;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= n)
                r = c;
        end
        return (r > 64'(VMAX)) ? VMAX : longint'(r);
    endfunction

    task automatic drag_slopes(input longint u, input longint w, input longint g,
                               output longint du, output longint dw);
        longint c, sp;
        c  = longint'(drag_c);
        sp = speed_of(sat_add(mul_q(u, u, 24), mul_q(w, w, 24)));
        du = sat_neg(mul_q(mul_q(u, c, 24), sp, 24));
        dw = sat_add(sat_neg(mul_q(mul_q(w, c, 24), sp, 24)), -g);
    endtask

    function automatic longint weigh(longint a, longint b, longint c, longint d);
        return sat_add(sat_add(sat_add(sat_add(sat_add(a, b), b), c), c), d) / 6;
    endfunction

    task automatic rk4_advance();
        longint h, g, hv, a1, b1, a2, b2, a3, b3, a4, b4, dh, dv, t;
        h  = longint'(step_c);
        g  = mul_q(longint'(grav_c), ONE, 24);
        hv = mul_q(h, ONE, 24);
        drag_slopes(vh, vv, g, a1, b1);
        drag_slopes(sat_add(vh, mul_q(h, a1, 24) / 2), sat_add(vv, mul_q(h, b1, 24) / 2),
                    g, a2, b2);
        drag_slopes(sat_add(vh, mul_q(h, a2, 24) / 2), sat_add(vv, mul_q(h, b2, 24) / 2),
                    g, a3, b3);
        drag_slopes(sat_add(vh, mul_q(h, a3, 24)), sat_add(vv, mul_q(h, b3, 24)), g, a4, b4);
        dh = weigh(a1, a2, a3, a4);
        dv = weigh(b1, b2, b3, b4);
        ox = px;
        oy = py;
        oz = pz;
        t  = mul_q(mul_q(dh / 2, h, 24), h, 24);
        py = sat_add(sat_add(py, mul_q(vh, h, 24)), t);
        t  = mul_q(mul_q(dv / 2, h, 24), h, 24);
        pz = sat_add(sat_add(pz, mul_q(vv, h, 24)), t);
        vh = sat_add(vh, mul_q(dh, h, 24));
        vv = sat_add(vv, mul_q(dv, h, 24));
        el = sat_add(el, hv);
    endtask

    function automatic logic [OUT_DATA_W-1:0] pack_result();
        logic [OUT_DATA_W-1:0] r;
        longint rx, ry, rox, roy;
        rx  = sat_add(mul_q(px, cos_c, 16), mul_q(py, sin_c, 16));
        ry  = sat_add(sat_neg(mul_q(px, sin_c, 16)), mul_q(py, cos_c, 16));
        rox = sat_add(mul_q(ox, cos_c, 16), mul_q(oy, sin_c, 16));
        roy = sat_add(sat_neg(mul_q(ox, sin_c, 16)), mul_q(oy, cos_c, 16));
        r = '0;
        r[47:0]    = rx[47:0];
        r[95:48]   = ry[47:0];
        r[143:96]  = pz[47:0];
        r[191:144] = rox[47:0];
        r[239:192] = roy[47:0];
        r[287:240] = oz[47:0];
        r[334:288] = el[46:0];
        r[382:335] = vh[47:0];
        r[430:383] = vv[47:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("prk_checker: %s mismatch got %h want %h", what, got, want);
        err_cnt++;
    endtask

    function automatic longint sext48(logic [47:0] v);
        return longint'(signed'(v));
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_DATA_W-1:0] want;
        string names[10];
        int offs[10];
        int wid[10];
        names = '{"rot_x", "rot_y", "rot_z", "rot_old_x", "rot_old_y", "rot_old_z",
                  "elapsed", "vel_h", "vel_v", "pad"};
        offs  = '{0, 48, 96, 144, 192, 240, 288, 335, 383, 431};
        wid   = '{48, 48, 48, 48, 48, 48, 47, 48, 48, 1};
        if (!i_rst_n) begin
            drag_c = RST_DRAG;
            grav_c = RST_GRAV;
            step_c = RST_STEP;
            cos_c = 65536;
            sin_c = 0;
            px = 0; py = 0; pz = 0; ox = 0; oy = 0; oz = 0; vh = 0; vv = 0; el = 0;
            result_q.delete();
            err_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DRAG: drag_c = i_cfg_data[C_W-1:0];
                    CFG_GRAV: grav_c = i_cfg_data[G_W-1:0];
                    CFG_STEP: step_c = i_cfg_data[H_W-1:0];
                    CFG_COS:  cos_c = longint'(signed'(i_cfg_data[TRIG_W-1:0]));
                    CFG_SIN:  sin_c = longint'(signed'(i_cfg_data[TRIG_W-1:0]));
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0]) begin
                    px = sext48(i_s_tdata[47:0]);
                    py = sext48(i_s_tdata[95:48]);
                    pz = sext48(i_s_tdata[143:96]);
                    vh = sext48(i_s_tdata[191:144]);
                    vv = sext48(i_s_tdata[239:192]);
                    el = 0;
                end else if (!i_s_tuser[1]) begin
                    rk4_advance();
                end
                result_q.push_back(pack_result());
            end
            if (i_m_tvalid && i_m_tready) begin
                if (result_q.size() == 0) begin
                    $display("prk_checker: unexpected result beat");
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        if (((i_m_tdata ^ want) >> offs[i]) & ((433'd1 << wid[i]) - 1))
                            report(names[i], 48'((i_m_tdata >> offs[i]) &
                                   ((433'd1 << wid[i]) - 1)),
                                   48'((want >> offs[i]) & ((433'd1 << wid[i]) - 1)));
                    end
                end
            end
        end
    end

endmodule

[dv/tb_top.sv]
module tb_top;
    import prk_pkg::*;

    localparam int WATCHDOG = 60000;
    localparam int HOLD_CYCLES = 8000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    int errors, pending;
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int quiet = 0;
    int seq_left = 0;

    always #1 i_clk = ~i_clk;

    projectile_rk4_drag_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    prk_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] scaled48();
        return 48'(signed'(rand48()) >>> $urandom_range(8, 40));
    endfunction

    task automatic push(input logic [IN_USER_W-1:0] u, input logic [IN_DATA_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= u;
        s_tdata <= d;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
    endtask

    task automatic load(input logic [47:0] x, y, z, h, v, input bit gnd);
        push({gnd, 1'b1}, {v, h, z, y, x});
    endtask

    task automatic tick(input bit gnd);
        push({gnd, 1'b0}, {rand48(), rand48(), rand48(), rand48(), rand48()});
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_all(input logic [31:0] c, g, h, input int cs, sn);
        write_cfg(CFG_DRAG, c);
        write_cfg(CFG_GRAV, g);
        write_cfg(CFG_STEP, h);
        write_cfg(CFG_COS, 32'(cs));
        write_cfg(CFG_SIN, 32'(sn));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_beat();
        if (seq_left == 0 || $urandom_range(0, 99) < 5) begin
            if ($urandom_range(0, 9) == 0)
                load(rand48(), rand48(), rand48(), rand48(), rand48(), $urandom_range(0, 1));
            else
                load(scaled48(), scaled48(), scaled48(), scaled48(), scaled48(),
                     $urandom_range(0, 9) == 0);
            seq_left = $urandom_range(1, 6);
        end else begin
            tick($urandom_range(0, 99) < 10);
            seq_left--;
        end
    endtask

    initial begin
        int ang;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        tick(1'b0);
        tick(1'b1);
        load(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
             48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0);
        tick(1'b0);
        tick(1'b0);
        load(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
             48'h8000_0000_0000, 48'h8000_0000_0000, 1'b1);
        tick(1'b0);
        tick(1'b1);
        load('0, '0, '0, '0, '0, 1'b0);
        tick(1'b0);
        load(48'd100 << 24, 48'd5 << 24, 48'd10 << 24, 48'd50 << 24, 48'd30 << 24, 1'b0);
        repeat (4) tick(1'b0);
        tick(1'b1);
        load(48'hFFFF_FF00_0000, 48'h0000_0100_0000, 48'hFFFF_F000_0000,
             48'hFFFF_EC00_0000, 48'h0000_3200_0000, 1'b1);
        repeat (3) tick(1'b0);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_all(32'(RST_DRAG), RST_GRAV, 32'(RST_STEP), 65536, 0);
                1: set_all(32'hFF_FFFF, 32'hFFFF_FFFF, 32'hFF_FFFF, -65536, 65536);
                2: set_all(0, 0, 0, 0, -65536);
                3: set_all(1, 1, 1, 65536, 65536);
                default: begin
                    ang = $urandom_range(0, 65536);
                    set_all($urandom_range(0, 32'hFF_FFFF), $urandom(),
                            $urandom_range(0, 32'h40_0000), ang,
                            ($urandom_range(0, 1) ? 1 : -1) * (65536 - ang));
                end
            endcase
            if (ph == 5) begin
                write_cfg(3'd5, $urandom());
                write_cfg(3'd6, $urandom());
                write_cfg(3'd7, $urandom());
                i_cfg_we <= 1'b0;
                @(posedge i_clk);
            end
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            if (ph == 4)
                hold_req = 1;
            seq_left = 0;
            repeat (244) random_beat();
            settle();
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
